FILE: rtl/msp_pkg.sv
// ============================================================================
// msp_pkg
// Shared types and constants for the multiplexed servo pulse generator.
// ============================================================================
`default_nettype none

package msp_pkg;

   // Channel and field geometry.
   localparam int NUM_CHANNELS = 8;
   localparam int CHAN_W       = 3;
   localparam int LINES_W      = 8;
   localparam int SLOT_W       = 24;
   localparam int POS_IN_W     = 17;
   localparam int POS_W        = 16;
   localparam int HALF_W       = 16;
   localparam int FRAC_W       = 33;
   localparam int PROD_W       = 57;
   localparam int FRAC_SHIFT   = 30;
   localparam int STEP_W       = 5;
   localparam int LIMITS_W     = 64;
   localparam int LIMIT_REGS   = 4;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   // Reset values and fixed-point constants.
   localparam logic [SLOT_W-1:0]   SLOT_LENGTH_RESET = SLOT_W'(40000);
   localparam logic [LIMITS_W-1:0] LIMITS_RESET      = 64'h8000_0000_8000_0000;
   localparam logic [POS_W-1:0]    POS_NEUTRAL       = 16'h4000;
   localparam logic [POS_W-1:0]    POS_ONE           = 16'h8000;

   // Input item modes.
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_SET  = 1'b1;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SLOT_LENGTH = 3'd0,
      REG_INVERT_MASK = 3'd1,
      REG_ATTACHED    = 3'd2,
      REG_LIMITS_01   = 3'd3,
      REG_LIMITS_23   = 3'd4,
      REG_LIMITS_45   = 3'd5,
      REG_LIMITS_67   = 3'd6
   } csr_index_type;

   // Operands handed to the width unit at the start of a slot.
   typedef struct packed {
      logic [HALF_W-1:0] offset;
      logic [HALF_W-1:0] range;
      logic [POS_W-1:0]  pos;
      logic              invert;
      logic [SLOT_W-1:0] top;
   } msp_width_req_type;

endpackage

`default_nettype wire

FILE: rtl/msp_intf.sv
// ============================================================================
// msp_intf
// Valid/ready channels for command transactions and result transactions.
// ============================================================================
`default_nettype none

interface msp_req_if import msp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [CHAN_W-1:0]          channel;
   logic signed [POS_IN_W-1:0] position;

   modport source (output valid, mode, channel, position, input ready);
   modport sink   (input valid, mode, channel, position, output ready);
endinterface

interface msp_rsp_if import msp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LINES_W-1:0] pulse_lines;
   logic [CHAN_W-1:0]  current_channel;
   logic               slot_start;

   modport source (output valid, pulse_lines, current_channel, slot_start, input ready);
   modport sink   (input valid, pulse_lines, current_channel, slot_start, output ready);
endinterface

`default_nettype wire

FILE: rtl/multiplexed_servo_pulse_generator.sv
// ============================================================================
// multiplexed_servo_pulse_generator
// Results: a set-position command or an in-slot tick gives its result in the
// cycle after acceptance; a slot-opening tick waits for the width unit and the
// CALC and EMIT states. Throughput: one transaction a cycle between slot
// boundaries while results are taken; the width unit's 24-step shift-and-add
// multiply stalls the input after a slot-start tick until its result issues.
// Synchronous reset: control registers take their defaults, no result is valid.
// ============================================================================
`default_nettype none

module multiplexed_servo_pulse_generator import msp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   msp_req_if.sink                    req_chan,
   msp_rsp_if.source                  rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_type;

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     slot_length_ff, slot_length_in;
   logic [LINES_W-1:0]    invert_ff, invert_in;
   logic [3:0]            attached_ff, attached_in;
   logic [LIMITS_W-1:0]   limits_ff [LIMIT_REGS];
   logic [LIMITS_W-1:0]   limits_in [LIMIT_REGS];
   logic [POS_W-1:0]      pos_ff [NUM_CHANNELS];
   logic [POS_W-1:0]      pos_in [NUM_CHANNELS];
   logic [SLOT_W-1:0]     slot_counter_ff, slot_counter_in;
   logic [CHAN_W-1:0]     active_index_ff, active_index_in;
   logic [SLOT_W-1:0]     pulse_remaining_ff, pulse_remaining_in;
   logic                  line_high_ff, line_high_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LINES_W-1:0]    rsp_lines_ff, rsp_lines_in;
   logic [CHAN_W-1:0]     rsp_chan_ff, rsp_chan_in;
   logic                  rsp_start_ff, rsp_start_in;

   logic                  cfg_wr;
   logic [CSR_IDX_W-1:0]  cfg_idx;
   logic [1:0]            lim_sel;
   logic                  req_accept;
   logic                  out_free;
   logic [SLOT_W-1:0]     eff_slot;
   logic [SLOT_W:0]       next_count;
   logic                  slot_begin;
   logic [CHAN_W-1:0]     next_index;
   logic [POS_W-1:0]      pos_clamped;
   logic [2*HALF_W-1:0]   limit_half;
   logic [LINES_W-1:0]    changed;
   msp_width_req_type     wreq;
   logic                  wstart;
   logic                  wdone;
   logic [SLOT_W-1:0]     wwidth;

   // Configuration port decode.
   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite & pready;
   assign cfg_idx = paddr[CSR_ADDR_W-1:3];
   assign lim_sel = 2'(cfg_idx - REG_LIMITS_01);
   assign changed = pwdata[LINES_W-1:0] ^ invert_ff;

   // Register readback.
   always_comb begin
      case (cfg_idx)
         REG_SLOT_LENGTH: prdata = CSR_DATA_W'(slot_length_ff);
         REG_INVERT_MASK: prdata = CSR_DATA_W'(invert_ff);
         REG_ATTACHED:    prdata = CSR_DATA_W'(attached_ff);
         REG_LIMITS_01, REG_LIMITS_23, REG_LIMITS_45, REG_LIMITS_67:
            prdata = limits_ff[lim_sel];
         default:         prdata = '0;
      endcase
   end

   // Slot timing: a zero slot length behaves as one tick.
   assign req_accept = req_chan.valid & req_chan.ready;
   assign out_free   = ~rsp_valid_ff | rsp_chan.ready;
   assign eff_slot   = (slot_length_ff == '0) ? SLOT_W'(1) : slot_length_ff;
   assign next_count = {1'b0, slot_counter_ff} + (SLOT_W+1)'(1);
   assign slot_begin = next_count >= {1'b0, eff_slot};
   assign next_index = (active_index_ff == CHAN_W'(NUM_CHANNELS - 1)) ?
                       '0 : active_index_ff + CHAN_W'(1);

   // Clamp the requested position to 0.0 .. 1.0.
   always_comb begin
      if (req_chan.position[POS_IN_W-1]) begin
         pos_clamped = '0;
      end else if (req_chan.position[POS_W-1:0] > POS_ONE) begin
         pos_clamped = POS_ONE;
      end else begin
         pos_clamped = req_chan.position[POS_W-1:0];
      end
   end

   // Operands for the channel that owns the upcoming slot.
   assign limit_half  = next_index[0] ? limits_ff[next_index[2:1]][LIMITS_W-1:2*HALF_W]
                                      : limits_ff[next_index[2:1]][2*HALF_W-1:0];
   assign wreq.offset = limit_half[HALF_W-1:0];
   assign wreq.range  = limit_half[2*HALF_W-1:HALF_W];
   assign wreq.pos    = pos_ff[next_index];
   assign wreq.invert = invert_ff[next_index];
   assign wreq.top    = eff_slot - SLOT_W'(1);
   assign wstart      = (state_ff == ST_IDLE) & req_accept & (req_chan.mode == MODE_TICK) &
                        slot_begin;

   msp_width_unit u_width (
      .clock (clock),
      .reset (reset),
      .start (wstart),
      .req   (wreq),
      .done  (wdone),
      .width (wwidth)
   );

   // Next-state logic for the sequencer, channel state and result register.
   always_comb begin
      state_in           = state_ff;
      slot_length_in     = slot_length_ff;
      invert_in          = invert_ff;
      attached_in        = attached_ff;
      limits_in          = limits_ff;
      pos_in             = pos_ff;
      slot_counter_in    = slot_counter_ff;
      active_index_in    = active_index_ff;
      pulse_remaining_in = pulse_remaining_ff;
      line_high_in       = line_high_ff;
      rsp_valid_in       = rsp_valid_ff & ~rsp_chan.ready;
      rsp_lines_in       = rsp_lines_ff;
      rsp_chan_in        = rsp_chan_ff;
      rsp_start_in       = rsp_start_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.mode == MODE_SET) begin
                  if ({1'b0, req_chan.channel} < 4'(NUM_CHANNELS)) begin
                     pos_in[req_chan.channel] = pos_clamped;
                  end
                  rsp_start_in = 1'b0;
                  rsp_valid_in = 1'b1;
               end else if (slot_begin) begin
                  // New slot: width and attached count decide if the line rises.
                  slot_counter_in = '0;
                  active_index_in = next_index;
                  state_in        = ST_CALC;
               end else begin
                  slot_counter_in = next_count[SLOT_W-1:0];
                  if (line_high_ff) begin
                     if (pulse_remaining_ff != '0) begin
                        pulse_remaining_in = pulse_remaining_ff - SLOT_W'(1);
                     end
                     if (pulse_remaining_in == '0) begin
                        line_high_in = 1'b0;
                     end
                  end
                  rsp_start_in = 1'b0;
                  rsp_valid_in = 1'b1;
               end
               rsp_lines_in = line_high_in ? (LINES_W'(1) << active_index_in) : '0;
               rsp_chan_in  = active_index_in;
            end
         end
         ST_CALC: begin
            if (wdone) begin
               if (({1'b0, active_index_ff} < attached_ff) && (wwidth != '0)) begin
                  line_high_in       = 1'b1;
                  pulse_remaining_in = wwidth;
               end else begin
                  line_high_in       = 1'b0;
                  pulse_remaining_in = '0;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_lines_in = line_high_ff ? (LINES_W'(1) << active_index_ff) : '0;
               rsp_chan_in  = active_index_ff;
               rsp_start_in = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes; limits writes and invert changes recenter their channels.
      if (cfg_wr) begin
         case (cfg_idx)
            REG_SLOT_LENGTH: slot_length_in = pwdata[SLOT_W-1:0];
            REG_INVERT_MASK: begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  if (changed[c]) begin
                     pos_in[c] = POS_NEUTRAL;
                  end
               end
               invert_in = pwdata[LINES_W-1:0];
            end
            REG_ATTACHED:    attached_in = pwdata[3:0];
            REG_LIMITS_01, REG_LIMITS_23, REG_LIMITS_45, REG_LIMITS_67: begin
               limits_in[lim_sel]        = pwdata;
               pos_in[{lim_sel, 1'b0}]   = POS_NEUTRAL;
               pos_in[{lim_sel, 1'b1}]   = POS_NEUTRAL;
            end
            default: begin
            end
         endcase
      end
   end

   // State, configuration and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         slot_length_ff     <= SLOT_LENGTH_RESET;
         invert_ff          <= '0;
         attached_ff        <= '0;
         for (int r = 0; r < LIMIT_REGS; r++) begin
            limits_ff[r] <= LIMITS_RESET;
         end
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            pos_ff[c] <= POS_NEUTRAL;
         end
         slot_counter_ff    <= '0;
         active_index_ff    <= '0;
         pulse_remaining_ff <= '0;
         line_high_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         slot_length_ff     <= slot_length_in;
         invert_ff          <= invert_in;
         attached_ff        <= attached_in;
         limits_ff          <= limits_in;
         pos_ff             <= pos_in;
         slot_counter_ff    <= slot_counter_in;
         active_index_ff    <= active_index_in;
         pulse_remaining_ff <= pulse_remaining_in;
         line_high_ff       <= line_high_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      rsp_lines_ff <= rsp_lines_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_start_ff <= rsp_start_in;
   end

   // Channel handshake outputs.
   assign req_chan.ready           = (state_ff == ST_IDLE) & out_free;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.pulse_lines     = rsp_lines_ff;
   assign rsp_chan.current_channel = rsp_chan_ff;
   assign rsp_chan.slot_start      = rsp_start_ff;

   // At most the owning channel's line is high in any result.
   a_one_line: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> $onehot0(rsp_chan.pulse_lines))
      else $error("more than one pulse line high");

   // A high line always has ticks left to run.
   a_line_has_width: assert property (@(posedge clock) disable iff (reset)
      line_high_ff |-> (pulse_remaining_ff != '0))
      else $error("line high with no remaining width");

   // The width unit only finishes while the sequencer waits for it.
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      wdone |-> (state_ff == ST_CALC))
      else $error("width result arrived outside the calculation state");

   // A slot-start tick restarts the counter and hands off to the width unit.
   a_slot_start: assert property (@(posedge clock) disable iff (reset)
      wstart |=> ((state_ff == ST_CALC) && (slot_counter_ff == '0)))
      else $error("slot start did not enter the calculation state");

endmodule

`default_nettype wire

FILE: rtl/msp_width_unit.sv
// ============================================================================
// msp_width_unit
// Computes one channel's pulse width with a shared shift-and-add multiplier:
// the FRAC state forms the Q.30 fraction, the MUL state multiplies it by the
// slot top one bit at a time, and the SAT state scales and saturates it.
// ============================================================================
`default_nettype none

module msp_width_unit import msp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire msp_width_req_type req,
   output logic                   done,
   output logic [SLOT_W-1:0]      width
);

   typedef enum logic [1:0] {W_IDLE, W_FRAC, W_MUL, W_SAT} wstate_type;

   wstate_type              state_ff, state_in;
   msp_width_req_type       req_ff, req_in;
   logic [PROD_W-1:0]       mcand_ff, mcand_in;
   logic [SLOT_W-1:0]       mplier_ff, mplier_in;
   logic [PROD_W-1:0]       acc_ff, acc_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    done_ff, done_in;
   logic [SLOT_W-1:0]       width_ff, width_in;

   logic [POS_W-1:0]               p_eff;
   logic [2*HALF_W-1:0]            p_times_range;
   logic [FRAC_W-1:0]              frac;
   logic [PROD_W-FRAC_SHIFT-1:0]   scaled;

   // Next-state logic for the sequencer and the datapath registers.
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      width_in  = width_ff;

      p_eff         = req_ff.invert ? (POS_ONE - req_ff.pos) : req_ff.pos;
      p_times_range = p_eff * req_ff.range;
      frac          = FRAC_W'({req_ff.offset, 15'b0}) + FRAC_W'(p_times_range);
      scaled        = acc_ff[PROD_W-1:FRAC_SHIFT];

      case (state_ff)
         W_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = W_FRAC;
            end
         end
         W_FRAC: begin
            mcand_in  = PROD_W'(frac);
            mplier_in = req_ff.top;
            acc_in    = '0;
            step_in   = '0;
            state_in  = W_MUL;
         end
         W_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SLOT_W - 1)) begin
               state_in = W_SAT;
            end
         end
         W_SAT: begin
            // Drop the Q.30 fraction and saturate to the slot top.
            if (scaled > (PROD_W-FRAC_SHIFT)'(req_ff.top)) begin
               width_in = req_ff.top;
            end else begin
               width_in = scaled[SLOT_W-1:0];
            end
            done_in  = 1'b1;
            state_in = W_IDLE;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   // Sequencer state and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      req_ff    <= req_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      width_ff  <= width_in;
   end

   assign done  = done_ff;
   assign width = width_ff;

endmodule

`default_nettype wire
